FILE: rtl/planar_pose_difference_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef PLANAR_POSE_DIFFERENCE_ASSERT_SVH
`define PLANAR_POSE_DIFFERENCE_ASSERT_SVH

// Checks a temporal property on every rising clock edge outside reset.
`define PPD_ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds on every rising clock edge outside reset.
`define PPD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: rtl/ppd_pkg.sv
package ppd_pkg;

  // Default configuration.
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int QUAT_FRAC_DEF      = 14;
  localparam int CORDIC_STAGES_DEF  = 16;

  // Fixed field widths.
  localparam int QUAT_W = 16;
  localparam int DIST_W = 32;
  localparam int YAW_W  = 15;

  // Angles are radians in Q.16.
  localparam int ANG_W       = 19;
  localparam int ANG_PI      = 205887;
  localparam int ANG_HALF_PI = 102944;
  localparam int YAW_MAX     = 25736;

  // The larger atan2 operand is normalized into [2^39, 2^40).
  localparam int NORM_MSB    = 39;
  localparam int NORM_TOP    = 40;
  localparam int LEFT_STAGES = 6;
  localparam int CORDIC_W    = 43;

  // Square root: one result bit per cell.
  localparam int RAD_W      = 64;
  localparam int REM_W      = 36;
  localparam int SQRT_STEPS = 32;
  localparam int DIST_DEPTH = 4 + SQRT_STEPS;

  // Status that travels with the atan2 operands.
  typedef struct packed {
    logic num_neg;
    logic den_neg;
    logic zero;
  } norm_side_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANG_W-1:0]    z;
    norm_side_t                 side;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIST_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic              sat;
  } sqrt_t;

  // Arctangent of 2^-i in Q.16, zero beyond the table.
  function automatic logic signed [ANG_W-1:0] atan_q16(int i);
    logic signed [ANG_W-1:0] t;
    case (i)
      0:       t = ANG_W'(51472);
      1:       t = ANG_W'(30386);
      2:       t = ANG_W'(16055);
      3:       t = ANG_W'(8150);
      4:       t = ANG_W'(4091);
      5:       t = ANG_W'(2047);
      6:       t = ANG_W'(1024);
      7:       t = ANG_W'(512);
      8:       t = ANG_W'(256);
      9:       t = ANG_W'(128);
      10:      t = ANG_W'(64);
      11:      t = ANG_W'(32);
      12:      t = ANG_W'(16);
      13:      t = ANG_W'(8);
      14:      t = ANG_W'(4);
      15:      t = ANG_W'(2);
      16:      t = ANG_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // Width of the operand magnitudes for a given quaternion fraction.
  function automatic int mag_width(int qfb);
    return (2 * qfb + 1 > 33) ? 2 * qfb + 1 : 33;
  endfunction

  function automatic int norm_width(int qfb);
    return (mag_width(qfb) > NORM_TOP) ? mag_width(qfb) : NORM_TOP;
  endfunction

  function automatic int right_stages(int qfb);
    return (mag_width(qfb) > NORM_TOP) ? $clog2(mag_width(qfb) - NORM_MSB) : 0;
  endfunction

  function automatic int yaw_depth(int qfb, int cs);
    return right_stages(qfb) + LEFT_STAGES + cs + 4;
  endfunction

  function automatic int pipe_depth(int qfb, int cs);
    return (yaw_depth(qfb, cs) > DIST_DEPTH) ? yaw_depth(qfb, cs) : DIST_DEPTH;
  endfunction

  // Cycles from an accepted request to its result strobe.
  function automatic int latency(int qfb, int cs);
    return pipe_depth(qfb, cs) + 1;
  endfunction

endpackage

FILE: rtl/ppd_norm_cell.sv
module ppd_norm_cell #(
  parameter int W     = 40,
  parameter int SHIFT = 1,
  parameter bit RIGHT = 1'b0
) (
  input  logic                  clk_i,
  input  logic [W-1:0]          ax_i,
  input  logic [W-1:0]          ay_i,
  input  ppd_pkg::norm_side_t   side_i,
  output logic [W-1:0]          ax_o,
  output logic [W-1:0]          ay_o,
  output ppd_pkg::norm_side_t   side_o
);

  logic [W-1:0] both;
  logic         take;

  // Decide on the shift from the larger operand.
  always_comb begin
    both = ax_i | ay_i;
    if (RIGHT) begin
      take = ((both >> (ppd_pkg::NORM_MSB + SHIFT)) != '0);
    end else begin
      take = ((both >> (ppd_pkg::NORM_TOP - SHIFT)) == '0);
    end
  end

  // Shift both operands together.
  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    if (!take) begin
      ax_o <= ax_i;
      ay_o <= ay_i;
    end else if (RIGHT) begin
      ax_o <= ax_i >> SHIFT;
      ay_o <= ay_i >> SHIFT;
    end else begin
      ax_o <= ax_i << SHIFT;
      ay_o <= ay_i << SHIFT;
    end
  end

endmodule

FILE: rtl/ppd_cordic_cell.sv
module ppd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  ppd_pkg::cordic_t  cin_i,
  output ppd_pkg::cordic_t  cout_o
);

  logic signed [ppd_pkg::CORDIC_W-1:0] xs;
  logic signed [ppd_pkg::CORDIC_W-1:0] ys;
  logic signed [ppd_pkg::ANG_W-1:0]    t;

  assign xs = cin_i.x >>> STAGE;
  assign ys = cin_i.y >>> STAGE;
  assign t  = ppd_pkg::atan_q16(STAGE);

  // One vectoring rotation toward the positive x axis.
  always_ff @(posedge clk_i) begin
    cout_o.side <= cin_i.side;
    if (cin_i.y > 0) begin
      cout_o.x <= cin_i.x + ys;
      cout_o.y <= cin_i.y - xs;
      cout_o.z <= cin_i.z + t;
    end else begin
      cout_o.x <= cin_i.x - ys;
      cout_o.y <= cin_i.y + xs;
      cout_o.z <= cin_i.z - t;
    end
  end

endmodule

FILE: rtl/ppd_sqrt_cell.sv
module ppd_sqrt_cell (
  input  logic            clk_i,
  input  ppd_pkg::sqrt_t  cin_i,
  output ppd_pkg::sqrt_t  cout_o
);

  logic [ppd_pkg::REM_W-1:0] cur;
  logic [ppd_pkg::REM_W-1:0] trial;
  logic                      ge;

  // Bring down the next two radicand bits and try a one digit.
  always_comb begin
    cur   = {cin_i.rem[ppd_pkg::REM_W-3:0], cin_i.rad[ppd_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, cin_i.root, 2'b01};
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk_i) begin
    cout_o.rem  <= ge ? cur - trial : cur;
    cout_o.root <= {cin_i.root[ppd_pkg::DIST_W-2:0], ge};
    cout_o.rad  <= cin_i.rad << 2;
    cout_o.sat  <= cin_i.sat;
  end

endmodule

FILE: rtl/ppd_delay.sv
module ppd_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  // Plain register line that aligns the shorter path with the longer one.
  if (DEPTH == 0) begin : g_none
    assign data_o = data_i;
  end else begin : g_line
    logic [W-1:0] tap_q [DEPTH];
    always_ff @(posedge clk_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
    assign data_o = tap_q[DEPTH-1];
  end

endmodule

FILE: rtl/planar_pose_difference.sv
// Distance and heading change between two planar poses.
//
// A request is taken at each rising edge where start is high and busy is low.
// busy never rises: the block is fully pipelined and takes one request in
// every cycle, back to back. Each request carries two positions (signed
// Q15.16) and two quaternions (signed, QUATERNION_FRACTION_BITS fraction).
//
// Its result appears on planar_distance_o and yaw_difference_o for exactly
// one cycle with done_o high, in request order. The depth is set by the
// square root chain, four front stages plus one cell per result bit, or
// by the yaw path (normalization cells plus CORDIC_STAGES rotation cells
// plus four stages) when that is longer. Throughput is one result per
// cycle. The receiver cannot stall the block and needs no handshake.
//
// Reset clears all valid flags, so nothing in flight is delivered after it.
module planar_pose_difference #(
  parameter int POSITION_WIDTH           = ppd_pkg::POSITION_WIDTH_DEF,
  parameter int QUATERNION_FRACTION_BITS = ppd_pkg::QUAT_FRAC_DEF,
  parameter int CORDIC_STAGES            = ppd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [POSITION_WIDTH-1:0]    first_pos_x_i,
  input  logic signed [POSITION_WIDTH-1:0]    first_pos_y_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   first_quat_x_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   first_quat_y_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   first_quat_z_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   first_quat_w_i,
  input  logic signed [POSITION_WIDTH-1:0]    second_pos_x_i,
  input  logic signed [POSITION_WIDTH-1:0]    second_pos_y_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   second_quat_x_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   second_quat_y_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   second_quat_z_i,
  input  logic signed [ppd_pkg::QUAT_W-1:0]   second_quat_w_i,
  output logic                                done_o,
  output logic [ppd_pkg::DIST_W-1:0]          planar_distance_o,
  output logic [ppd_pkg::YAW_W-1:0]           yaw_difference_o
);

  localparam int QW          = ppd_pkg::QUAT_W;
  localparam int PW          = POSITION_WIDTH;
  localparam int AW          = ppd_pkg::ANG_W;
  localparam int MAG_W       = ppd_pkg::mag_width(QUATERNION_FRACTION_BITS);
  localparam int DEN_W       = MAG_W + 1;
  localparam int NORM_W      = ppd_pkg::norm_width(QUATERNION_FRACTION_BITS);
  localparam int RIGHT_ST    = ppd_pkg::right_stages(QUATERNION_FRACTION_BITS);
  localparam int NORM_ST     = RIGHT_ST + ppd_pkg::LEFT_STAGES;
  localparam int YAW_DEPTH   = ppd_pkg::yaw_depth(QUATERNION_FRACTION_BITS, CORDIC_STAGES);
  localparam int PIPE_DEPTH  = ppd_pkg::pipe_depth(QUATERNION_FRACTION_BITS, CORDIC_STAGES);

  localparam logic signed [AW-1:0] PI_A   = AW'(ppd_pkg::ANG_PI);
  localparam logic signed [AW-1:0] HALF_A = AW'(ppd_pkg::ANG_HALF_PI);
  localparam logic signed [AW:0]   PI_D   = (AW+1)'(ppd_pkg::ANG_PI);
  localparam logic signed [AW:0]   TWO_PI = (AW+1)'(2 * ppd_pkg::ANG_PI);

  logic                     accept;
  logic [PIPE_DEPTH:1]      vld_q;
  logic                     done_q;

  logic signed [QW-1:0]     quat [2][4];
  logic signed [AW-1:0]     yaw_q [2];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid flags travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[PIPE_DEPTH-1:1], accept};
      done_q <= vld_q[PIPE_DEPTH];
    end
  end

  assign quat[0][0] = first_quat_x_i;
  assign quat[0][1] = first_quat_y_i;
  assign quat[0][2] = first_quat_z_i;
  assign quat[0][3] = first_quat_w_i;
  assign quat[1][0] = second_quat_x_i;
  assign quat[1][1] = second_quat_y_i;
  assign quat[1][2] = second_quat_z_i;
  assign quat[1][3] = second_quat_w_i;

  // Yaw of each pose: products, atan2 operands, normalization, CORDIC.
  for (genvar p = 0; p < 2; p++) begin : g_pose
    logic signed [2*QW-1:0]    wz_q, xy_q, yy_q, zz_q;
    logic signed [2*QW:0]      sum_ab, sum_cd;
    logic signed [DEN_W-1:0]   num_w, den_w;
    logic [DEN_W-1:0]          num_mag, den_mag;
    logic [NORM_W-1:0]         nax [NORM_ST+1];
    logic [NORM_W-1:0]         nay [NORM_ST+1];
    ppd_pkg::norm_side_t       nside [NORM_ST+1];
    ppd_pkg::cordic_t          cor [CORDIC_STAGES+1];
    logic signed [AW-1:0]      ang, yaw_c;

    // Quaternion products.
    always_ff @(posedge clk_i) begin
      wz_q <= quat[p][3] * quat[p][2];
      xy_q <= quat[p][0] * quat[p][1];
      yy_q <= quat[p][1] * quat[p][1];
      zz_q <= quat[p][2] * quat[p][2];
    end

    // Numerator and denominator of the atan2, with their magnitudes.
    always_comb begin
      sum_ab  = (2*QW+1)'(wz_q) + (2*QW+1)'(xy_q);
      sum_cd  = (2*QW+1)'(yy_q) + (2*QW+1)'(zz_q);
      num_w   = DEN_W'(sum_ab) <<< 1;
      den_w   = (DEN_W'(1) <<< (2 * QUATERNION_FRACTION_BITS)) - (DEN_W'(sum_cd) <<< 1);
      num_mag = num_w[DEN_W-1] ? -num_w : num_w;
      den_mag = den_w[DEN_W-1] ? -den_w : den_w;
    end

    always_ff @(posedge clk_i) begin
      nax[0]           <= NORM_W'(den_mag);
      nay[0]           <= NORM_W'(num_mag);
      nside[0].num_neg <= num_w[DEN_W-1];
      nside[0].den_neg <= den_w[DEN_W-1];
      nside[0].zero    <= (num_w == '0) && (den_w == '0);
    end

    // Normalization cells: right shifts first, then left shifts.
    for (genvar s = 0; s < NORM_ST; s++) begin : g_norm
      localparam bit IS_RIGHT = (s < RIGHT_ST);
      localparam int AMOUNT   = IS_RIGHT ? (2 ** (RIGHT_ST - 1 - s))
                                         : (2 ** (ppd_pkg::LEFT_STAGES - 1 - (s - RIGHT_ST)));
      ppd_norm_cell #(
        .W     (NORM_W),
        .SHIFT (AMOUNT),
        .RIGHT (IS_RIGHT)
      ) u_norm (
        .clk_i  (clk_i),
        .ax_i   (nax[s]),
        .ay_i   (nay[s]),
        .side_i (nside[s]),
        .ax_o   (nax[s+1]),
        .ay_o   (nay[s+1]),
        .side_o (nside[s+1])
      );
    end

    assign cor[0].x    = signed'(ppd_pkg::CORDIC_W'(nax[NORM_ST][ppd_pkg::NORM_MSB:0]));
    assign cor[0].y    = signed'(ppd_pkg::CORDIC_W'(nay[NORM_ST][ppd_pkg::NORM_MSB:0]));
    assign cor[0].z    = '0;
    assign cor[0].side = nside[NORM_ST];

    // Vectoring rotation cells.
    for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_rot
      ppd_cordic_cell #(
        .STAGE (c)
      ) u_rot (
        .clk_i  (clk_i),
        .cin_i  (cor[c]),
        .cout_o (cor[c+1])
      );
    end

    // Clamp the first-quadrant angle and map it to its quadrant.
    always_comb begin
      if (cor[CORDIC_STAGES].z < 0) begin
        ang = '0;
      end else if (cor[CORDIC_STAGES].z > HALF_A) begin
        ang = HALF_A;
      end else begin
        ang = cor[CORDIC_STAGES].z;
      end
      if (cor[CORDIC_STAGES].side.zero) begin
        yaw_c = '0;
      end else if (!cor[CORDIC_STAGES].side.den_neg) begin
        yaw_c = cor[CORDIC_STAGES].side.num_neg ? -ang : ang;
      end else begin
        yaw_c = cor[CORDIC_STAGES].side.num_neg ? ang - PI_A : PI_A - ang;
      end
    end

    always_ff @(posedge clk_i) begin
      yaw_q[p] <= yaw_c;
    end
  end

  // Wrap the yaw difference into [-pi, pi).
  logic signed [AW:0]       diff_c, diff_q;
  logic [AW:0]              diff_mag;
  logic [AW:0]              diff_rnd;
  logic [ppd_pkg::YAW_W-1:0] yaw_fin, yaw_dly;

  always_comb begin
    diff_c = (AW+1)'(yaw_q[1]) - (AW+1)'(yaw_q[0]);
    if (diff_c >= PI_D) begin
      diff_c = diff_c - TWO_PI;
    end
    if (diff_c < -PI_D) begin
      diff_c = diff_c + TWO_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_c;
  end

  // Magnitude, rounded half up to Q2.13.
  always_comb begin
    diff_mag = diff_q[AW] ? -diff_q : diff_q;
    diff_rnd = (diff_mag + (AW+1)'(4)) >> 3;
    if (diff_rnd > (AW+1)'(ppd_pkg::YAW_MAX)) begin
      yaw_fin = ppd_pkg::YAW_W'(ppd_pkg::YAW_MAX);
    end else begin
      yaw_fin = diff_rnd[ppd_pkg::YAW_W-1:0];
    end
  end

  // Position differences and their magnitudes.
  logic signed [PW:0]        dx_q, dy_q;
  logic [PW:0]               adx, ady;
  logic [ppd_pkg::DIST_W-1:0] adx_q, ady_q;
  logic                      far_b_q, far_c_q;
  logic [2*ppd_pkg::DIST_W-1:0] sqx_c, sqy_c, sqx_q, sqy_q;
  logic [2*ppd_pkg::DIST_W:0]   sum_e;
  ppd_pkg::sqrt_t            sq [ppd_pkg::SQRT_STEPS+1];
  logic [ppd_pkg::DIST_W-1:0] dist_fin, dist_dly;

  always_ff @(posedge clk_i) begin
    dx_q <= (PW+1)'(first_pos_x_i) - (PW+1)'(second_pos_x_i);
    dy_q <= (PW+1)'(first_pos_y_i) - (PW+1)'(second_pos_y_i);
  end

  assign adx = dx_q[PW] ? -dx_q : dx_q;
  assign ady = dy_q[PW] ? -dy_q : dy_q;

  always_ff @(posedge clk_i) begin
    adx_q   <= ppd_pkg::DIST_W'(adx);
    ady_q   <= ppd_pkg::DIST_W'(ady);
    far_b_q <= ((adx >> ppd_pkg::DIST_W) != '0) || ((ady >> ppd_pkg::DIST_W) != '0);
  end

  // Squares, one 32 by 32 product each.
  assign sqx_c = adx_q * adx_q;
  assign sqy_c = ady_q * ady_q;

  always_ff @(posedge clk_i) begin
    sqx_q   <= sqx_c;
    sqy_q   <= sqy_c;
    far_c_q <= far_b_q;
  end

  // Sum of squares; a carry out saturates the distance.
  assign sum_e = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    sq[0].rem  <= '0;
    sq[0].root <= '0;
    sq[0].rad  <= sum_e[2*ppd_pkg::DIST_W-1:0];
    sq[0].sat  <= far_c_q || sum_e[2*ppd_pkg::DIST_W];
  end

  // Square root cells, one result bit each.
  for (genvar k = 0; k < ppd_pkg::SQRT_STEPS; k++) begin : g_sqrt
    ppd_sqrt_cell u_sqrt (
      .clk_i  (clk_i),
      .cin_i  (sq[k]),
      .cout_o (sq[k+1])
    );
  end

  assign dist_fin = sq[ppd_pkg::SQRT_STEPS].sat ? '1 : sq[ppd_pkg::SQRT_STEPS].root;

  // Align both results with the deeper path.
  ppd_delay #(
    .W     (ppd_pkg::YAW_W),
    .DEPTH (PIPE_DEPTH - YAW_DEPTH)
  ) u_yaw_dly (
    .clk_i  (clk_i),
    .data_i (yaw_fin),
    .data_o (yaw_dly)
  );

  ppd_delay #(
    .W     (ppd_pkg::DIST_W),
    .DEPTH (PIPE_DEPTH - ppd_pkg::DIST_DEPTH)
  ) u_dist_dly (
    .clk_i  (clk_i),
    .data_i (dist_fin),
    .data_o (dist_dly)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    planar_distance_o <= dist_dly;
    yaw_difference_o  <= yaw_dly;
  end

  assign done_o = done_q;

endmodule

FILE: rtl/ppd_checker.sv
`include "planar_pose_difference_assert.svh"

module ppd_checker #(
  parameter int POSITION_WIDTH           = ppd_pkg::POSITION_WIDTH_DEF,
  parameter int QUATERNION_FRACTION_BITS = ppd_pkg::QUAT_FRAC_DEF,
  parameter int CORDIC_STAGES            = ppd_pkg::CORDIC_STAGES_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [POSITION_WIDTH-1:0]         first_pos_x_i,
  input logic [POSITION_WIDTH-1:0]         first_pos_y_i,
  input logic [ppd_pkg::QUAT_W-1:0]        first_quat_x_i,
  input logic [ppd_pkg::QUAT_W-1:0]        first_quat_y_i,
  input logic [ppd_pkg::QUAT_W-1:0]        first_quat_z_i,
  input logic [ppd_pkg::QUAT_W-1:0]        first_quat_w_i,
  input logic [POSITION_WIDTH-1:0]         second_pos_x_i,
  input logic [POSITION_WIDTH-1:0]         second_pos_y_i,
  input logic [ppd_pkg::QUAT_W-1:0]        second_quat_x_i,
  input logic [ppd_pkg::QUAT_W-1:0]        second_quat_y_i,
  input logic [ppd_pkg::QUAT_W-1:0]        second_quat_z_i,
  input logic [ppd_pkg::QUAT_W-1:0]        second_quat_w_i,
  input logic                              done_o,
  input logic [ppd_pkg::DIST_W-1:0]        planar_distance_o,
  input logic [ppd_pkg::YAW_W-1:0]         yaw_difference_o
);

  localparam int LAT = ppd_pkg::latency(QUATERNION_FRACTION_BITS, CORDIC_STAGES);

  logic acc;
  logic same_pos;
  logic same_quat;

  assign acc       = start && !busy;
  assign same_pos  = (first_pos_x_i == second_pos_x_i) && (first_pos_y_i == second_pos_y_i);
  assign same_quat = (first_quat_x_i == second_quat_x_i) && (first_quat_y_i == second_quat_y_i)
                  && (first_quat_z_i == second_quat_z_i) && (first_quat_w_i == second_quat_w_i);

  // Every result comes from a request taken a fixed time before.
  `PPD_ASSERT_PROP(a_done_has_request, clk_i, rst_ni, done_o |-> $past(acc, LAT), "result without request")

  // The heading change never exceeds a half turn.
  `PPD_ASSERT_ALWAYS(a_yaw_range, clk_i, rst_ni, !done_o || (yaw_difference_o <= ppd_pkg::YAW_W'(ppd_pkg::YAW_MAX)), "yaw out of range")

  // Equal positions give zero distance.
  `PPD_ASSERT_PROP(a_zero_dist, clk_i, rst_ni, (done_o && $past(acc && same_pos, LAT)) |-> (planar_distance_o == '0), "nonzero distance")

  // Equal quaternions give zero heading change.
  `PPD_ASSERT_PROP(a_zero_yaw, clk_i, rst_ni, (done_o && $past(acc && same_quat, LAT)) |-> (yaw_difference_o == '0), "nonzero yaw")

endmodule

bind planar_pose_difference ppd_checker #(
  .POSITION_WIDTH           (POSITION_WIDTH),
  .QUATERNION_FRACTION_BITS (QUATERNION_FRACTION_BITS),
  .CORDIC_STAGES            (CORDIC_STAGES)
) u_ppd_checker (.*);

FILE: dv/planar_pose_difference_tb.sv
`timescale 1ns / 100ps

module planar_pose_difference_tb;

  localparam int POS_W       = ppd_pkg::POSITION_WIDTH_DEF;
  localparam int QFB         = ppd_pkg::QUAT_FRAC_DEF;
  localparam int STAGES      = ppd_pkg::CORDIC_STAGES_DEF;
  localparam int PIPE_CYCLES = ppd_pkg::latency(QFB, STAGES);
  localparam int CYCLE_LIMIT = 400000;
  localparam longint TURN_PI   = 205887;
  localparam longint QUARTER   = 102944;
  localparam longint YAW_CLAMP = 25736;
  localparam longint ARCTAN_Q16 [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                           512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic signed [POS_W-1:0]           p1x, p1y, p2x, p2y;
    logic signed [ppd_pkg::QUAT_W-1:0] q1x, q1y, q1z, q1w;
    logic signed [ppd_pkg::QUAT_W-1:0] q2x, q2y, q2z, q2w;
  } pose_pair_t;

  typedef struct {
    logic [ppd_pkg::DIST_W-1:0] distance;
    logic [ppd_pkg::YAW_W-1:0]  yaw;
  } pose_delta_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [POS_W-1:0]  first_pos_x_i, first_pos_y_i, second_pos_x_i, second_pos_y_i;
  logic signed [ppd_pkg::QUAT_W-1:0] first_quat_x_i, first_quat_y_i;
  logic signed [ppd_pkg::QUAT_W-1:0] first_quat_z_i, first_quat_w_i;
  logic signed [ppd_pkg::QUAT_W-1:0] second_quat_x_i, second_quat_y_i;
  logic signed [ppd_pkg::QUAT_W-1:0] second_quat_z_i, second_quat_w_i;
  logic done_o;
  logic [ppd_pkg::DIST_W-1:0] planar_distance_o;
  logic [ppd_pkg::YAW_W-1:0]  yaw_difference_o;

  pose_delta_t pending_deltas[$];
  int error_count = 0;
  int cycle_count = 0;

  planar_pose_difference uut (
    .clk_i, .rst_ni, .start, .busy,
    .first_pos_x_i, .first_pos_y_i,
    .first_quat_x_i, .first_quat_y_i, .first_quat_z_i, .first_quat_w_i,
    .second_pos_x_i, .second_pos_y_i,
    .second_quat_x_i, .second_quat_y_i, .second_quat_z_i, .second_quat_w_i,
    .done_o, .planar_distance_o, .yaw_difference_o
  );

  // Free-running clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Vectoring CORDIC arctangent in Q.16 radians over the full circle.
  function automatic longint atan2_q16(longint num, longint den);
    logic [63:0] ax, ay;
    longint x, y, z, xs, ys, a;
    ax = den < 0 ? -den : den;
    ay = num < 0 ? -num : num;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    while (ax >= (64'd1 << 40) || ay >= (64'd1 << 40)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    while (ax < (64'd1 << 39) && ay < (64'd1 << 39)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = longint'(ax);
    y = longint'(ay);
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + (i <= 16 ? ARCTAN_Q16[i] : 0);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - (i <= 16 ? ARCTAN_Q16[i] : 0);
      end
    end
    a = z < 0 ? 0 : (z > QUARTER ? QUARTER : z);
    if (den >= 0) return num >= 0 ? a : -a;
    return num >= 0 ? TURN_PI - a : -(TURN_PI - a);
  endfunction

  // Heading of an unnormalized quaternion (x, y, z, w).
  function automatic longint heading_q16(longint qx, longint qy, longint qz, longint qw);
    longint num, den;
    num = 2 * (qw * qz + qx * qy);
    den = (longint'(1) << (2 * QFB)) - 2 * (qy * qy + qz * qz);
    return atan2_q16(num, den);
  endfunction

  // Floor of the square root of a 64-bit value.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic pose_delta_t predict_pose_delta(pose_pair_t p);
    pose_delta_t r;
    longint dx, dy, d;
    logic [63:0] adx, ady, sx, s;
    dx = longint'(p.p1x) - longint'(p.p2x);
    dy = longint'(p.p1y) - longint'(p.p2y);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (adx >= (64'd1 << 32) || ady >= (64'd1 << 32)) begin
      r.distance = '1;
    end else begin
      sx = adx * adx;
      s = sx + ady * ady;
      r.distance = (s < sx) ? '1 : ppd_pkg::DIST_W'(floor_sqrt(s));
    end
    d = heading_q16(p.q2x, p.q2y, p.q2z, p.q2w) - heading_q16(p.q1x, p.q1y, p.q1z, p.q1w);
    if (d >= TURN_PI) d = d - 2 * TURN_PI;
    if (d < -TURN_PI) d = d + 2 * TURN_PI;
    if (d < 0) d = -d;
    d = (d + 4) >>> 3;
    r.yaw = ppd_pkg::YAW_W'(d > YAW_CLAMP ? YAW_CLAMP : d);
    return r;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_pair(pose_pair_t p);
    first_pos_x_i   <= p.p1x;
    first_pos_y_i   <= p.p1y;
    first_quat_x_i  <= p.q1x;
    first_quat_y_i  <= p.q1y;
    first_quat_z_i  <= p.q1z;
    first_quat_w_i  <= p.q1w;
    second_pos_x_i  <= p.p2x;
    second_pos_y_i  <= p.p2y;
    second_quat_x_i <= p.q2x;
    second_quat_y_i <= p.q2y;
    second_quat_z_i <= p.q2z;
    second_quat_w_i <= p.q2w;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_deltas.push_back(predict_pose_delta(p));
  endtask

  task automatic pause_requests(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ppd_pkg::QUAT_W-1:0] random_quat_component();
    if ($urandom_range(0, 3) == 0) return ppd_pkg::QUAT_W'($urandom);
    return ppd_pkg::QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic pose_pair_t random_pair();
    pose_pair_t p;
    p.p1x = POS_W'($urandom);
    p.p1y = POS_W'($urandom);
    case ($urandom_range(0, 2))
      0: begin
        p.p2x = POS_W'($urandom);
        p.p2y = POS_W'($urandom);
      end
      1: begin
        p.p2x = p.p1x + POS_W'(int'($urandom_range(0, 2000000)) - 1000000);
        p.p2y = p.p1y + POS_W'(int'($urandom_range(0, 2000000)) - 1000000);
      end
      default: begin
        p.p2x = p.p1x + POS_W'(int'($urandom_range(0, 200)) - 100);
        p.p2y = p.p1y + POS_W'(int'($urandom_range(0, 200)) - 100);
      end
    endcase
    p.q1x = random_quat_component();
    p.q1y = random_quat_component();
    p.q1z = random_quat_component();
    p.q1w = random_quat_component();
    p.q2x = random_quat_component();
    p.q2y = random_quat_component();
    p.q2z = random_quat_component();
    p.q2w = random_quat_component();
    return p;
  endfunction

  function automatic pose_pair_t make_pair(int p1x, int p1y, int p2x, int p2y,
                                           int q1x, int q1y, int q1z, int q1w,
                                           int q2x, int q2y, int q2z, int q2w);
    pose_pair_t p;
    p.p1x = POS_W'(p1x); p.p1y = POS_W'(p1y); p.p2x = POS_W'(p2x); p.p2y = POS_W'(p2y);
    p.q1x = ppd_pkg::QUAT_W'(q1x); p.q1y = ppd_pkg::QUAT_W'(q1y);
    p.q1z = ppd_pkg::QUAT_W'(q1z); p.q1w = ppd_pkg::QUAT_W'(q1w);
    p.q2x = ppd_pkg::QUAT_W'(q2x); p.q2y = ppd_pkg::QUAT_W'(q2y);
    p.q2z = ppd_pkg::QUAT_W'(q2z); p.q2w = ppd_pkg::QUAT_W'(q2w);
    return p;
  endfunction

  // Field extremes: position wraparound and odd quaternion codes.
  task automatic test_field_extremes();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_pair(make_pair(32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 1, 1, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_pair(make_pair(32'h80000000, 32'h80000000, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(65536, 0, 0, 65536, 16384, 16384, 16384, 16384,
                        -16384, -16384, -16384, -16384));
    send_pair(make_pair(-7, 3, 5, -9, -32768, -32768, -32768, -32768,
                        32767, 32767, 32767, 32767));
    pause_requests(random_gap());
    send_pair(make_pair(3, 4, 0, 0, 32767, -32768, 1, -1, 21845, -21846, 12345, -6789));
  endtask

  // Yaw corner cases: zero operands, negative x axis and the half turn wrap.
  task automatic test_heading_cases();
    // Both atan2 operands zero on the first pose.
    send_pair(make_pair(0, 0, 0, 0, -5000, 8192, 8192, 5000, 0, 0, 0, 16384));
    // Pure half turn about z: yaw of +pi against zero, then reversed.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 16384, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 16384));
    // Denominator negative with numerator just below zero.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, -1));
    // Quarter turns in each direction, then near half turns in each direction.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 11585, 11585, 0, 0, -11585, 11585));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 16384, 1, 0, 0, -16384, 1));
    pause_requests(random_gap());
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 16384, -1, 0, 0, 16384, 1));
  endtask

  // An unbroken burst with no gaps.
  task automatic test_back_to_back(int count);
    repeat (count) send_pair(random_pair());
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) begin
      pause_requests(random_gap());
      send_pair(random_pair());
    end
  endtask

  // Compare each result against the oldest prediction.
  always @(posedge clk_i) begin
    pose_delta_t want;
    if (rst_ni && done_o) begin
      if (pending_deltas.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = pending_deltas.pop_front();
        if (planar_distance_o !== want.distance) begin
          $error("planar_distance: expected %0d, got %0d", want.distance, planar_distance_o);
          error_count++;
        end
        if (yaw_difference_o !== want.yaw) begin
          $error("yaw_difference: expected %0d, got %0d", want.yaw, yaw_difference_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    first_pos_x_i = '0; first_pos_y_i = '0; second_pos_x_i = '0; second_pos_y_i = '0;
    first_quat_x_i = '0; first_quat_y_i = '0; first_quat_z_i = '0; first_quat_w_i = '0;
    second_quat_x_i = '0; second_quat_y_i = '0; second_quat_z_i = '0;
    second_quat_w_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_heading_cases();
    test_back_to_back(200);
    test_random_pairs(1300);
    test_back_to_back(200);
    pause_requests(1);

    while (pending_deltas.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_norm_cell.sv
rtl/ppd_cordic_cell.sv
rtl/ppd_sqrt_cell.sv
rtl/ppd_delay.sv
rtl/planar_pose_difference.sv
rtl/ppd_checker.sv
dv/planar_pose_difference_tb.sv
